FILE: rtl/fpa_pkg.sv
// ----------------------------------------------------------------------------
// fpa_pkg
// Shared constants, codes and types of the Q24.8 fixed-point ALU.
// ----------------------------------------------------------------------------
`default_nettype none

package fpa_pkg;

  // Number format
  localparam int FRAC_BITS = 8;
  localparam int WORD_BITS = 32;
  localparam int SAT_BITS  = (WORD_BITS < 32) ? WORD_BITS : 32;

  // Divider: numerator is |a| shifted up by the fraction, one cell per bit
  localparam int NUM_BITS  = 32 + FRAC_BITS;
  // Entry register, one register per divider cell, output register
  localparam int LATENCY   = NUM_BITS + 2;

  localparam logic signed [63:0] SAT_HI = (64'sd1 <<< (SAT_BITS - 1)) - 64'sd1;
  localparam logic signed [63:0] SAT_LO = -SAT_HI - 64'sd1;
  localparam logic [63:0]        HALF   = (64'd1 << FRAC_BITS) >> 1;
  localparam logic [63:0]        FMASK  = (64'd1 << FRAC_BITS) - 64'd1;

  // Operation codes
  localparam logic [3:0] FUNC_ADD  = 4'd0;
  localparam logic [3:0] FUNC_SUB  = 4'd1;
  localparam logic [3:0] FUNC_MUL  = 4'd2;
  localparam logic [3:0] FUNC_DIV  = 4'd3;
  localparam logic [3:0] FUNC_CMP  = 4'd4;
  localparam logic [3:0] FUNC_MIN  = 4'd5;
  localparam logic [3:0] FUNC_MAX  = 4'd6;
  localparam logic [3:0] FUNC_INC  = 4'd7;
  localparam logic [3:0] FUNC_DEC  = 4'd8;
  localparam logic [3:0] FUNC_FINT = 4'd9;
  localparam logic [3:0] FUNC_TINT = 4'd10;

  // Finished result of one request
  typedef struct packed {
    logic [31:0] result;
    logic        overflow;
    logic        div_by_zero;
    logic        greater;
    logic        less;
  } res_t;

  // Word handed from cell to cell
  typedef struct packed {
    logic                valid;
    logic                is_div;
    logic                neg;
    res_t                res;
    logic [31:0]         rem;
    logic [NUM_BITS-1:0] num;
    logic [NUM_BITS-1:0] quo;
    logic [31:0]         den;
  } pipe_t;

  // Clamp to the signed result range
  function automatic res_t saturate(input logic signed [63:0] v);
    res_t r;
    r = '0;
    if (v > SAT_HI) begin
      r.result   = SAT_HI[31:0];
      r.overflow = 1'b1;
    end else if (v < SAT_LO) begin
      r.result   = SAT_LO[31:0];
      r.overflow = 1'b1;
    end else begin
      r.result = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/fpa_prep.sv
// ----------------------------------------------------------------------------
// fpa_prep
// Decodes a request, finishes every non-divide operation and sets up the
// operands of the divider chain.
// ----------------------------------------------------------------------------
`default_nettype none

module fpa_prep (
  input  logic                valid_i,
  input  logic [3:0]          func_i,
  input  logic signed [31:0]  a_i,
  input  logic signed [31:0]  b_i,
  input  logic signed [63:0]  prod_i,
  output fpa_pkg::pipe_t      pipe_o
);

  logic signed [63:0] a64, b64, mval, tval;
  logic [63:0]        pmag, pq;
  logic [31:0]        amag, bmag;

  always_comb begin
    a64  = {{32{a_i[31]}}, a_i};
    b64  = {{32{b_i[31]}}, b_i};
    // multiply rounding half away from zero on the magnitude
    pmag = prod_i[63] ? (64'd0 - prod_i) : prod_i;
    pq   = (pmag + fpa_pkg::HALF) >> fpa_pkg::FRAC_BITS;
    mval = prod_i[63] ? -$signed(pq) : $signed(pq);
    // truncation toward zero for fixed to integer
    tval = (a64 + (a_i[31] ? $signed(fpa_pkg::FMASK) : 64'sd0)) >>> fpa_pkg::FRAC_BITS;
    amag = a_i[31] ? (32'd0 - a_i) : a_i;
    bmag = b_i[31] ? (32'd0 - b_i) : b_i;
  end

  always_comb begin
    pipe_o        = '0;
    pipe_o.valid  = valid_i;
    pipe_o.neg    = a_i[31] ^ b_i[31];
    pipe_o.num    = {amag, {fpa_pkg::FRAC_BITS{1'b0}}};
    pipe_o.den    = bmag;
    unique case (func_i)
      fpa_pkg::FUNC_ADD:  pipe_o.res = fpa_pkg::saturate(a64 + b64);
      fpa_pkg::FUNC_SUB:  pipe_o.res = fpa_pkg::saturate(a64 - b64);
      fpa_pkg::FUNC_MUL:  pipe_o.res = fpa_pkg::saturate(mval);
      fpa_pkg::FUNC_DIV: begin
        if (b_i == 32'sd0) pipe_o.res.div_by_zero = 1'b1;
        else               pipe_o.is_div = 1'b1;
      end
      fpa_pkg::FUNC_CMP: begin
        pipe_o.res.greater = a_i > b_i;
        pipe_o.res.less    = a_i < b_i;
      end
      fpa_pkg::FUNC_MIN:  pipe_o.res.result = (a_i < b_i) ? a_i : b_i;
      fpa_pkg::FUNC_MAX:  pipe_o.res.result = (a_i > b_i) ? a_i : b_i;
      fpa_pkg::FUNC_INC:  pipe_o.res = fpa_pkg::saturate(a64 + 64'sd1);
      fpa_pkg::FUNC_DEC:  pipe_o.res = fpa_pkg::saturate(a64 - 64'sd1);
      fpa_pkg::FUNC_FINT: pipe_o.res = fpa_pkg::saturate(a64 <<< fpa_pkg::FRAC_BITS);
      fpa_pkg::FUNC_TINT: pipe_o.res.result = tval[31:0];
      default:            pipe_o.res = '0;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/fpa_div_cell.sv
// ----------------------------------------------------------------------------
// fpa_div_cell
// One restoring division step: brings in one numerator bit, produces one
// quotient bit and hands the word on to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module fpa_div_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  fpa_pkg::pipe_t pipe_i,
  output fpa_pkg::pipe_t pipe_o
);

  fpa_pkg::pipe_t pipe_d, pipe_q;
  logic [32:0]    rem2;
  logic           ge;

  // trial subtract
  always_comb begin
    rem2   = {pipe_i.rem, pipe_i.num[fpa_pkg::NUM_BITS-1]};
    ge     = rem2 >= {1'b0, pipe_i.den};
    pipe_d = pipe_i;
    pipe_d.rem = ge ? 32'(rem2 - {1'b0, pipe_i.den}) : rem2[31:0];
    pipe_d.num = {pipe_i.num[fpa_pkg::NUM_BITS-2:0], 1'b0};
    pipe_d.quo = {pipe_i.quo[fpa_pkg::NUM_BITS-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pipe_q <= '0;
    end else begin
      pipe_q <= pipe_d;
    end
  end

  assign pipe_o = pipe_q;

endmodule

`default_nettype wire

FILE: rtl/fpa_finish.sv
// ----------------------------------------------------------------------------
// fpa_finish
// Rounds, signs and clamps the divider quotient and registers the result.
// ----------------------------------------------------------------------------
`default_nettype none

module fpa_finish (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  fpa_pkg::pipe_t pipe_i,
  output logic           valid_o,
  output fpa_pkg::res_t  res_o
);

  logic [63:0]   q;
  logic signed [63:0] qs;
  fpa_pkg::res_t res_d, res_q;
  logic          valid_q;

  // round half away from zero: 2*rem >= den
  always_comb begin
    q  = {{(64-fpa_pkg::NUM_BITS){1'b0}}, pipe_i.quo}
       + {63'd0, ({pipe_i.rem, 1'b0} >= {1'b0, pipe_i.den})};
    qs = pipe_i.neg ? -$signed(q) : $signed(q);
    res_d = pipe_i.is_div ? fpa_pkg::saturate(qs) : pipe_i.res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= pipe_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_i.valid) begin
      res_q <= res_d;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

`default_nettype wire

FILE: rtl/fixed_point_alu_core.sv
// ----------------------------------------------------------------------------
// fixed_point_alu_core
// Signed Q24.8 fixed-point ALU with a pipelined bit-per-cell divider.
// ----------------------------------------------------------------------------
//  channel  | ports                                   | handshake
//  request  | func_i, operand_a_i, operand_b_i        | start && !busy
//  result   | result_o, overflow_o, div_by_zero_o,    | valid_o, one cycle
//           | greater_o, less_o                       |
//
// One request per cycle; busy is never raised.
// Every request passes the entry register with the multiplier, one cell per
// quotient bit of the divider chain and the output register.
// All operations take this same path, so results leave in request order.
// Reset clears the valid bits of the pipeline; results cannot be stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_point_alu_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [3:0]         func_i,
  input  logic signed [31:0] operand_a_i,
  input  logic signed [31:0] operand_b_i,
  output logic               valid_o,
  output logic signed [31:0] result_o,
  output logic               overflow_o,
  output logic               div_by_zero_o,
  output logic               greater_o,
  output logic               less_o
);

  logic               ent_valid_q;
  logic [3:0]         func_q;
  logic signed [31:0] a_q, b_q;
  logic signed [63:0] prod_q;
  fpa_pkg::pipe_t     chain [0:fpa_pkg::NUM_BITS];
  fpa_pkg::res_t      res;

  assign busy = 1'b0;

  // entry register with the multiplier
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_valid_q <= 1'b0;
    end else begin
      ent_valid_q <= start;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q <= func_i;
    a_q    <= operand_a_i;
    b_q    <= operand_b_i;
    prod_q <= operand_a_i * operand_b_i;
  end

  fpa_prep u_prep (
    .valid_i (ent_valid_q),
    .func_i  (func_q),
    .a_i     (a_q),
    .b_i     (b_q),
    .prod_i  (prod_q),
    .pipe_o  (chain[0])
  );

  // divider chain
  for (genvar k = 0; k < fpa_pkg::NUM_BITS; k++) begin : g_cell
    fpa_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .pipe_i (chain[k]),
      .pipe_o (chain[k+1])
    );
  end

  fpa_finish u_finish (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .pipe_i  (chain[fpa_pkg::NUM_BITS]),
    .valid_o (valid_o),
    .res_o   (res)
  );

  assign result_o      = res.result;
  assign overflow_o    = res.overflow;
  assign div_by_zero_o = res.div_by_zero;
  assign greater_o     = res.greater;
  assign less_o        = res.less;

endmodule

`default_nettype wire

FILE: rtl/fpa_checker.sv
// ----------------------------------------------------------------------------
// fpa_checker
// Port-level checks of the fixed-point ALU, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module fpa_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        valid_o,
  input logic [31:0] result_o,
  input logic        overflow_o,
  input logic        div_by_zero_o,
  input logic        greater_o,
  input logic        less_o
);

  // every accepted request brings a result on valid_o
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##(fpa_pkg::LATENCY) valid_o)
    else $error("result missing after request");

  // divide by zero gives a clean zero
  a_dz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && div_by_zero_o) |-> (result_o == 32'd0 && !overflow_o))
    else $error("divide by zero result not zero");

  // compare flags exclusive and only with a zero word
  a_cmp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && (greater_o || less_o)) |->
      (!(greater_o && less_o) && result_o == 32'd0 && !overflow_o && !div_by_zero_o))
    else $error("compare flags inconsistent");

  // no result without a request
  a_nospur: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start, fpa_pkg::LATENCY))
    else $error("result without request");

endmodule

bind fixed_point_alu_core fpa_checker u_fpa_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .valid_o       (valid_o),
  .result_o      (result_o),
  .overflow_o    (overflow_o),
  .div_by_zero_o (div_by_zero_o),
  .greater_o     (greater_o),
  .less_o        (less_o)
);

`default_nettype wire

FILE: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the Q24.8 fixed-point ALU against an in-bench predictor. Directed
// corner requests are followed by random requests sent in bursts; every
// result is compared field by field with the oldest expected result.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [3:0]         func;
    logic signed [31:0] opa;
    logic signed [31:0] opb;
  } alu_req_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [3:0]         func_i = '0;
  logic signed [31:0] operand_a_i = '0;
  logic signed [31:0] operand_b_i = '0;
  logic               valid_o;
  logic signed [31:0] result_o;
  logic               overflow_o;
  logic               div_by_zero_o;
  logic               greater_o;
  logic               less_o;

  alu_req_t       pending_reqs[$];
  fpa_pkg::res_t  expected_res[$];
  int             mismatches = 0;
  int             checked = 0;
  int             sent = 0;
  int             gap_left = 0;
  int             burst_left = 0;
  bit             stim_done = 1'b0;

  fixed_point_alu_core uut (.*);

  always #6 clk_i = ~clk_i;

  // Clamp to the signed result range
  function automatic fpa_pkg::res_t clamp_word(input logic signed [63:0] v);
    fpa_pkg::res_t r;
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    r = '0;
    hi = (64'sd1 <<< (fpa_pkg::SAT_BITS - 1)) - 64'sd1;
    lo = -hi - 64'sd1;
    if (v > hi) begin
      r.result = hi[31:0];
      r.overflow = 1'b1;
    end else if (v < lo) begin
      r.result = lo[31:0];
      r.overflow = 1'b1;
    end else begin
      r.result = v[31:0];
    end
    return r;
  endfunction

  // Expected result of one request
  function automatic fpa_pkg::res_t alu_predict(input alu_req_t q);
    fpa_pkg::res_t r;
    logic signed [63:0] a;
    logic signed [63:0] b;
    logic signed [63:0] p;
    logic [63:0] m;
    logic [63:0] n;
    logic [63:0] d;
    logic signed [63:0] s;
    r = '0;
    a = 64'(q.opa);
    b = 64'(q.opb);
    case (q.func)
      fpa_pkg::FUNC_ADD: r = clamp_word(a + b);
      fpa_pkg::FUNC_SUB: r = clamp_word(a - b);
      fpa_pkg::FUNC_MUL: begin
        p = a * b;
        m = (p < 0) ? -p : p;
        m = (m + ((64'd1 << fpa_pkg::FRAC_BITS) >> 1)) >> fpa_pkg::FRAC_BITS;
        s = m;
        r = clamp_word((p < 0) ? -s : s);
      end
      fpa_pkg::FUNC_DIV: begin
        if (b == 0) begin
          r.div_by_zero = 1'b1;
        end else begin
          n = ((a < 0) ? -a : a) << fpa_pkg::FRAC_BITS;
          d = (b < 0) ? -b : b;
          s = (2 * n + d) / (2 * d);
          r = clamp_word(((a < 0) != (b < 0)) ? -s : s);
        end
      end
      fpa_pkg::FUNC_CMP: begin
        r.greater = a > b;
        r.less = a < b;
      end
      fpa_pkg::FUNC_MIN: r.result = (a < b) ? q.opa : q.opb;
      fpa_pkg::FUNC_MAX: r.result = (a > b) ? q.opa : q.opb;
      fpa_pkg::FUNC_INC: r = clamp_word(a + 1);
      fpa_pkg::FUNC_DEC: r = clamp_word(a - 1);
      fpa_pkg::FUNC_FINT: r = clamp_word(a * (64'sd1 <<< fpa_pkg::FRAC_BITS));
      fpa_pkg::FUNC_TINT: begin
        s = a / (64'sd1 <<< fpa_pkg::FRAC_BITS);
        r.result = s[31:0];
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    $display("mismatch %0s: got %h expected %h (result %0d)", what, got, want, checked);
  endtask

  function automatic logic signed [31:0] rand_operand();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 8) == 0 ? 32'sh7fffffff : 32'sh80000000;
      1: return $signed($urandom_range(0, 2048)) - 1024;
      2: return $signed($urandom_range(0, 1 << 20)) - (1 << 19);
      3: return $urandom_range(0, 3) == 0 ? 0 : 32'sh0100;
      default: return $urandom;
    endcase
  endfunction

  // Put one request on the ports and plan the next gap
  task automatic q_drive(input alu_req_t q);
    start <= 1'b1;
    func_i <= q.func;
    operand_a_i <= q.opa;
    operand_b_i <= q.opb;
    if (burst_left > 0) begin
      burst_left <= burst_left - 1;
    end else begin
      burst_left <= $urandom_range(0, 40);
      gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
    end
  endtask

  // Fill the request queue
  initial begin
    logic signed [31:0] corners[6];
    alu_req_t q;
    corners = '{32'sh7fffffff, 32'sh80000000, 0, 32'sh100, -32'sh80, 32'sh1ff};
    for (int f = 0; f < 16; f++) begin
      q.func = 4'(f);
      q.opa = corners[f % 6];
      q.opb = corners[(f + 1) % 6];
      pending_reqs.push_back(q);
    end
    pending_reqs.push_back(alu_req_t'{fpa_pkg::FUNC_DIV, 32'sh7fffffff, 32'sh0});
    pending_reqs.push_back(alu_req_t'{fpa_pkg::FUNC_DIV, 32'sh7fffffff, 32'sh1});
    pending_reqs.push_back(alu_req_t'{fpa_pkg::FUNC_MUL, 32'sh80000000, 32'sh80000000});
    pending_reqs.push_back(alu_req_t'{fpa_pkg::FUNC_MUL, 32'sh180, 32'shffffff80});
    pending_reqs.push_back(alu_req_t'{fpa_pkg::FUNC_TINT, -32'sh1ff, 32'sh0});
    pending_reqs.push_back(alu_req_t'{fpa_pkg::FUNC_MIN, 32'sh5, 32'sh5});
    pending_reqs.push_back(alu_req_t'{fpa_pkg::FUNC_CMP, 32'sh5, 32'sh5});
    for (int i = 0; i < 1750; i++) begin
      q.func = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(11, 15))
                                            : 4'($urandom_range(0, 10));
      q.opa = rand_operand();
      q.opb = ($urandom_range(0, 15) == 0) ? 0 : rand_operand();
      pending_reqs.push_back(q);
    end
  end

  // Reset
  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Request driver: bursts with random gaps
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        expected_res.push_back(alu_predict(alu_req_t'{func_i, operand_a_i, operand_b_i}));
        sent++;
      end
      if (!(start && busy)) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          start <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          q_drive(pending_reqs.pop_front());
        end else begin
          start <= 1'b0;
          stim_done <= 1'b1;
        end
      end
    end
  end

  // Result monitor
  always @(posedge clk_i) begin
    fpa_pkg::res_t want;
    if (rst_ni && valid_o) begin
      if (expected_res.size() == 0) begin
        report_mismatch("unexpected result", result_o, 32'd0);
      end else begin
        want = expected_res.pop_front();
        if (result_o !== want.result) report_mismatch("result", result_o, want.result);
        if (overflow_o !== want.overflow)
          report_mismatch("overflow", 32'(overflow_o), 32'(want.overflow));
        if (div_by_zero_o !== want.div_by_zero)
          report_mismatch("div_by_zero", 32'(div_by_zero_o), 32'(want.div_by_zero));
        if (greater_o !== want.greater)
          report_mismatch("greater", 32'(greater_o), 32'(want.greater));
        if (less_o !== want.less)
          report_mismatch("less", 32'(less_o), 32'(want.less));
      end
      checked++;
    end
  end

  // Drain and verdict
  initial begin
    wait (stim_done);
    while (expected_res.size() > 0) @(posedge clk_i);
    repeat (fpa_pkg::LATENCY + 10) @(posedge clk_i);
    $display("Sent %0d requests over all operation codes, checked %0d results.",
             sent, checked);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2ms;
    $display("FAIL");
    $finish;
  end

endmodule

`default_nettype wire
